### sv/pls_pkg.sv
package pls_pkg;

  // Q16.16 rendering of 0.0016 (round to nearest): 105/65536
  localparam logic [31:0] GravityStep = 32'd105;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgStartScaleX = 3'd0,
    CfgStartScaleY = 3'd1,
    CfgStartScaleZ = 3'd2,
    CfgEndScaleX   = 3'd3,
    CfgEndScaleY   = 3'd4,
    CfgEndScaleZ   = 3'd5,
    CfgLifetime    = 3'd6,
    CfgFrameCount  = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Item function codes
  localparam logic FuncTick = 1'b0;
  localparam logic FuncFire = 1'b1;

  // Divider: 32-bit magnitude dividend, 16-bit divisor, quotient bits per cycle
  localparam int unsigned DividendW       = 32;
  localparam int unsigned DivisorW        = 16;
  localparam int unsigned DivBitsPerCycle = 4;

  typedef struct packed {
    logic              func;
    logic signed [31:0] start_pos_x;
    logic signed [31:0] start_pos_y;
    logic signed [31:0] start_pos_z;
    logic signed [31:0] start_vel_x;
    logic signed [31:0] start_vel_y;
    logic signed [31:0] start_vel_z;
    logic              use_gravity;
  } in_item_t;

  typedef struct packed {
    logic               active;
    logic               fire_accepted;
    logic signed [31:0] cur_pos_x;
    logic signed [31:0] cur_pos_y;
    logic signed [31:0] cur_pos_z;
    logic signed [15:0] cur_scale_x;
    logic signed [15:0] cur_scale_y;
    logic signed [15:0] cur_scale_z;
    logic [7:0]         frame_index;
    logic [15:0]        age;
  } out_item_t;

endpackage

### sv/particle_lifetime_step.sv
// Channel  Signals                               Direction  Transfer when
// -------  ------------------------------------  ---------  ----------------------
// in       in_valid_i, in_ready_o, in_data_i      input      in_valid_i & in_ready_o
// out      out_valid_o, out_ready_i, out_data_o   output     out_valid_o & out_ready_i
// cfg      cfg_we_i, cfg_idx_i, cfg_data_i        input      cfg_we_i
//
// One item at a time. Each division passes S_MUL, S_LOAD, S_DIV and S_POST;
// a fire, or a tick on a free slot, runs one and then writes the result from
// S_OUT, and a tick on a live slot runs four. The next input is taken once the
// result is in the output register, from the cycle in which it turns valid.
// The cost is set by one shared 18x18 multiplier feeding one 32-by-16 divider
// that retires 4 quotient bits per cycle: three scale divisions plus one frame
// division per live tick, one frame division otherwise.
// Reset clears the slot, the scales, position and velocity; lifetime and frame
// count reset to 1. A stalled output holds in its register; the next input is
// taken meanwhile and its result waits for the register to empty.
module particle_lifetime_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pls_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pls_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [pls_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pls_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned DivCycles = pls_pkg::DividendW / pls_pkg::DivBitsPerCycle;
  localparam int unsigned DivCntW   = $clog2(DivCycles);
  localparam logic [1:0]  StepFrame = 2'd3;
  localparam logic [1:0]  StepLastAxis = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_POST,
    S_OUT
  } state_e;

  // Configuration registers
  logic [15:0] start_scale_q [3];
  logic [15:0] end_scale_q   [3];
  logic [15:0] life_q;
  logic [7:0]  frames_q;

  // Slot state
  state_e      state_q;
  logic        live_q;
  logic [15:0] age_q;
  logic [31:0] pos_q   [3];
  logic [31:0] vel_q   [3];
  logic        grav_q;
  logic [15:0] scale_q [3];
  logic        acc_q;
  logic [7:0]  frame_q;
  logic [1:0]  step_q;

  // Shared arithmetic
  logic signed [35:0]               prod_q;
  logic                             neg_q;
  logic [pls_pkg::DivisorW-1:0]     rem_q;
  logic [pls_pkg::DividendW-1:0]    quo_q;
  logic [DivCntW-1:0]               cnt_q;

  logic                             out_valid_q;
  pls_pkg::out_item_t               out_q;

  logic [15:0]        len_eff;
  logic [1:0]         axis;
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] prod;
  logic [35:0]        prod_abs;
  logic [pls_pkg::DivisorW-1:0]  div_rem;
  logic [pls_pkg::DividendW-1:0] div_quo;
  logic [pls_pkg::DivisorW:0]    div_trial;
  logic [15:0]        q_signed;
  logic               in_xfer;
  logic               out_free;
  pls_pkg::out_item_t out_d;

  assign len_eff  = (life_q == 16'd0) ? 16'd1 : life_q;
  assign axis     = (step_q == StepFrame) ? 2'd0 : step_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Multiplier operands: (start - end) * (L - age) per axis, age * F for the frame
  always_comb begin
    if (step_q == StepFrame) begin
      mul_a = {2'b00, age_q};
      mul_b = {10'd0, frames_q};
    end else begin
      mul_a = $signed({{2{start_scale_q[axis][15]}}, start_scale_q[axis]})
            - $signed({{2{end_scale_q[axis][15]}}, end_scale_q[axis]});
      mul_b = $signed({2'b00, len_eff}) - $signed({2'b00, age_q});
    end
  end

  assign prod     = mul_a * mul_b;
  assign prod_abs = prod_q[35] ? (~prod_q + 36'd1) : prod_q;

  // Restoring divider, several quotient bits per cycle
  always_comb begin
    div_rem = rem_q;
    div_quo = quo_q;
    div_trial = '0;
    for (int k = 0; k < pls_pkg::DivBitsPerCycle; k++) begin
      div_trial = {div_rem, div_quo[pls_pkg::DividendW-1]};
      if (div_trial >= {1'b0, len_eff}) begin
        div_trial = div_trial - {1'b0, len_eff};
        div_quo   = {div_quo[pls_pkg::DividendW-2:0], 1'b1};
      end else begin
        div_quo   = {div_quo[pls_pkg::DividendW-2:0], 1'b0};
      end
      div_rem = div_trial[pls_pkg::DivisorW-1:0];
    end
  end

  // Quotient with sign restored, low 16 bits (scale wraps at 16 bits)
  assign q_signed = neg_q ? (16'd0 - quo_q[15:0]) : quo_q[15:0];

  // Result word
  always_comb begin
    out_d.active        = live_q;
    out_d.fire_accepted = acc_q;
    out_d.cur_pos_x     = pos_q[0];
    out_d.cur_pos_y     = pos_q[1];
    out_d.cur_pos_z     = pos_q[2];
    out_d.cur_scale_x   = scale_q[0];
    out_d.cur_scale_y   = scale_q[1];
    out_d.cur_scale_z   = scale_q[2];
    out_d.frame_index   = frame_q;
    out_d.age           = age_q;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        start_scale_q[i] <= '0;
        end_scale_q[i]   <= '0;
      end
      life_q   <= 16'd1;
      frames_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pls_pkg::CfgStartScaleX: start_scale_q[0] <= cfg_data_i;
        pls_pkg::CfgStartScaleY: start_scale_q[1] <= cfg_data_i;
        pls_pkg::CfgStartScaleZ: start_scale_q[2] <= cfg_data_i;
        pls_pkg::CfgEndScaleX:   end_scale_q[0]   <= cfg_data_i;
        pls_pkg::CfgEndScaleY:   end_scale_q[1]   <= cfg_data_i;
        pls_pkg::CfgEndScaleZ:   end_scale_q[2]   <= cfg_data_i;
        pls_pkg::CfgLifetime:    life_q           <= cfg_data_i;
        pls_pkg::CfgFrameCount:  frames_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer, slot state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= 1'b0;
      age_q       <= '0;
      grav_q      <= 1'b0;
      acc_q       <= 1'b0;
      step_q      <= StepFrame;
      cnt_q       <= '0;
      prod_q      <= '0;
      neg_q       <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      frame_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]   <= '0;
        vel_q[i]   <= '0;
        scale_q[i] <= '0;
      end
    end else begin
      // taken result leaves; in S_OUT a new one replaces it instead
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_MUL;
            if (in_data_i.func == pls_pkg::FuncFire) begin
              step_q <= StepFrame;
              acc_q  <= !live_q;
              if (!live_q) begin
                pos_q[0] <= in_data_i.start_pos_x;
                pos_q[1] <= in_data_i.start_pos_y;
                pos_q[2] <= in_data_i.start_pos_z;
                vel_q[0] <= in_data_i.start_vel_x;
                vel_q[1] <= in_data_i.start_vel_y;
                vel_q[2] <= in_data_i.start_vel_z;
                grav_q   <= in_data_i.use_gravity;
                live_q   <= 1'b1;
              end
            end else begin
              acc_q <= 1'b0;
              if (live_q) begin
                // live tick: age, motion and gravity now, scales follow
                age_q  <= age_q + 16'd1;
                step_q <= 2'd0;
                for (int i = 0; i < 3; i++) begin
                  pos_q[i] <= pos_q[i] + vel_q[i];
                end
                if (grav_q) begin
                  vel_q[1] <= vel_q[1] - pls_pkg::GravityStep;
                end
              end else begin
                step_q <= StepFrame;
              end
            end
          end
        end
        S_MUL: begin
          prod_q  <= prod;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          neg_q   <= prod_q[35];
          quo_q   <= prod_abs[pls_pkg::DividendW-1:0];
          rem_q   <= '0;
          cnt_q   <= DivCntW'(DivCycles - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= div_rem;
          quo_q <= div_quo;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (step_q == StepFrame) begin
            // frame index, capped at F-1; no frames gives 0
            if (frames_q == 8'd0) begin
              frame_q <= 8'd0;
            end else if (quo_q >= {24'd0, frames_q}) begin
              frame_q <= frames_q - 8'd1;
            end else begin
              frame_q <= quo_q[7:0];
            end
            state_q <= S_OUT;
          end else begin
            scale_q[axis] <= end_scale_q[axis] + q_signed;
            state_q       <= S_MUL;
            if (step_q == StepLastAxis) begin
              step_q <= StepFrame;
              if (age_q >= len_eff) begin
                live_q <= 1'b0;
                age_q  <= '0;
              end
            end else begin
              step_q <= step_q + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A free slot always has a cleared age
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !live_q |-> (age_q == 16'd0))
    else $error("free slot with nonzero age");

  // Partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < len_eff))
    else $error("divider remainder out of range");

  // An accepted fire always leaves the slot live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fire_accepted) |-> out_data_o.active)
    else $error("accepted fire reported with inactive slot");

  // A fire on a live slot leaves the x position, the y velocity and liveness untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.func == pls_pkg::FuncFire && live_q)
      |=> ($stable(pos_q[0]) && $stable(vel_q[1]) && live_q))
    else $error("fire on live slot changed state");

  // Frame index never reaches a nonzero frame count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && frames_q != 8'd0) |-> (frame_q < frames_q))
    else $error("frame index beyond frame count");

endmodule
